[rtl/fuzzy_subsequence_scorer_macros.svh]
// ---------------------------------------------------------------------------
// Fuzzy subsequence scorer assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef FUZZY_SUBSEQUENCE_SCORER_MACROS_SVH
`define FUZZY_SUBSEQUENCE_SCORER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fss assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fss assertion failed");

`endif

[rtl/fss_pkg.sv]
// ---------------------------------------------------------------------------
// Fuzzy subsequence scorer package
// Widths, register codes, score weights and character class helpers.
// ---------------------------------------------------------------------------
package fss_pkg;

	localparam int QUERY_MAX_DEF = 8;
	localparam int CHAR_W        = 8;
	localparam int LEN_W         = 4;
	localparam int TPOS_W        = 4;
	localparam int TPOS_SAT      = 9;
	localparam int SCORE_W       = 8;
	localparam int BONUS_W       = 6;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_IDX_W     = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUERY_CHARS  = 1'b0,
		REG_QUERY_LENGTH = 1'b1
	} cfg_reg_t;

	localparam logic [BONUS_W-1:0]   PTS_MATCH    = 6'd5;
	localparam logic [BONUS_W-1:0]   PTS_FIRST    = 6'd25;
	localparam logic [BONUS_W-1:0]   PTS_BOUNDARY = 6'd10;
	localparam logic [BONUS_W-1:0]   PTS_RUN      = 6'd8;
	localparam logic [SCORE_W:0]     PTS_PREFIX   = 9'd40;

	typedef struct packed {
		logic [CHAR_W-1:0] target_char;
		logic              char_present;
		logic              last_of_target;
	} item_t;

	function automatic logic is_upper(input logic [CHAR_W-1:0] ch);
		return (ch >= 8'h41) && (ch <= 8'h5A);
	endfunction

	function automatic logic is_lower(input logic [CHAR_W-1:0] ch);
		return (ch >= 8'h61) && (ch <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
		return (ch >= 8'h30) && (ch <= 8'h39);
	endfunction

	function automatic logic is_alnum(input logic [CHAR_W-1:0] ch);
		return is_upper(ch) || is_lower(ch) || is_digit(ch);
	endfunction

	// Only A-Z fold; every other byte passes through unchanged.
	function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] ch);
		return is_upper(ch) ? (ch + 8'h20) : ch;
	endfunction

	function automatic logic word_boundary(input logic [CHAR_W-1:0] prev,
			input logic [CHAR_W-1:0] cur);
		return (is_lower(prev) && is_upper(cur)) || (!is_alnum(prev) && is_alnum(cur));
	endfunction

endpackage

[rtl/fss_in_if.sv]
// ---------------------------------------------------------------------------
// Fuzzy subsequence scorer character channel
// Valid/ready channel carrying one candidate character per word.
// ---------------------------------------------------------------------------
interface fss_in_if;
	logic                      valid;
	logic                      ready;
	logic [fss_pkg::CHAR_W-1:0] target_char;
	logic                      char_present;
	logic                      last_of_target;

	modport source (output valid, output target_char, output char_present,
		output last_of_target, input ready);
	modport sink (input valid, input target_char, input char_present,
		input last_of_target, output ready);
endinterface

[rtl/fss_out_if.sv]
// ---------------------------------------------------------------------------
// Fuzzy subsequence scorer result channel
// Valid/ready channel carrying one score word per candidate.
// ---------------------------------------------------------------------------
interface fss_out_if;
	logic                        valid;
	logic                        ready;
	logic [fss_pkg::SCORE_W-1:0] match_score;
	logic                        matched;

	modport source (output valid, output match_score, output matched, input ready);
	modport sink (input valid, input match_score, input matched, output ready);
endinterface

[rtl/fss_cfg_regs.sv]
// ---------------------------------------------------------------------------
// Fuzzy subsequence scorer configuration registers
// Query characters and length, with the length clamped to the query size.
// ---------------------------------------------------------------------------
module fss_cfg_regs #(
	parameter int QUERY_MAX = fss_pkg::QUERY_MAX_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [fss_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [fss_pkg::CFG_DATA_W-1:0]            cfg_data,
	output logic [QUERY_MAX-1:0][fss_pkg::CHAR_W-1:0] query_bytes,
	output logic [fss_pkg::LEN_W-1:0]                 eff_len
);
	import fss_pkg::*;

	logic [QUERY_MAX-1:0][CHAR_W-1:0] chars_q;
	logic [LEN_W-1:0]                 len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q <= '0;
			len_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_QUERY_CHARS: begin
					chars_q <= cfg_data[QUERY_MAX*CHAR_W-1:0];
				end
				REG_QUERY_LENGTH: begin
					len_q <= cfg_data[LEN_W-1:0];
				end
			endcase
		end
	end

	assign query_bytes = chars_q;
	assign eff_len     = (len_q > LEN_W'(QUERY_MAX)) ? LEN_W'(QUERY_MAX) : len_q;

endmodule

[rtl/fss_in_stage.sv]
// ---------------------------------------------------------------------------
// Fuzzy subsequence scorer input register
// Captures one character word and holds it until the match core takes it.
// ---------------------------------------------------------------------------
module fss_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	fss_in_if.sink          in_ch,
	output logic            item_valid,
	output fss_pkg::item_t  item,
	input  logic            item_take
);
	import fss_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	// A new word may enter in the same cycle the held one is consumed.
	assign in_ch.ready = !valid_s1 || item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.target_char    <= in_ch.target_char;
			item_s1.char_present   <= in_ch.char_present;
			item_s1.last_of_target <= in_ch.last_of_target;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

[rtl/fss_match_core.sv]
// ---------------------------------------------------------------------------
// Fuzzy subsequence scorer match core
// Per-character greedy match, score update and registered result word.
// ---------------------------------------------------------------------------
`include "fuzzy_subsequence_scorer_macros.svh"

module fss_match_core #(
	parameter int QUERY_MAX = fss_pkg::QUERY_MAX_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      item_valid,
	input  fss_pkg::item_t                            item,
	output logic                                      item_take,
	input  logic [QUERY_MAX-1:0][fss_pkg::CHAR_W-1:0] query_bytes,
	input  logic [fss_pkg::LEN_W-1:0]                 eff_len,
	fss_out_if.source                                 out_ch
);
	import fss_pkg::*;

	localparam int IDX_W = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;

	logic [LEN_W-1:0]   qpos_q, qpos_d;
	logic [SCORE_W-1:0] score_q, score_d;
	logic [CHAR_W-1:0]  prev_q, prev_d;
	logic               last_match_q, last_match_d;
	logic [TPOS_W-1:0]  tpos_q, tpos_d;
	logic               prefix_q, prefix_d;

	logic               out_valid_q;
	logic [SCORE_W-1:0] out_score_q;
	logic               out_matched_q;

	logic [CHAR_W-1:0]  lc, tq, mq;
	logic [BONUS_W-1:0] bonus;
	logic               done;
	logic [SCORE_W:0]   total;
	logic [SCORE_W-1:0] final_score;
	logic               fire;

	// The last character of a candidate needs the result register free.
	assign fire      = item_valid && (!item.last_of_target || !out_valid_q || out_ch.ready);
	assign item_take = fire;

	always_comb begin
		lc = fold(item.target_char);
		// Both lookups are only used when their position is below the length.
		tq = fold(query_bytes[tpos_q[IDX_W-1:0]]);
		mq = fold(query_bytes[qpos_q[IDX_W-1:0]]);

		bonus = PTS_MATCH;
		if (tpos_q == '0) begin
			bonus = bonus + PTS_FIRST;
		end else if (word_boundary(prev_q, item.target_char)) begin
			bonus = bonus + PTS_BOUNDARY;
		end
		if (last_match_q) begin
			bonus = bonus + PTS_RUN;
		end

		qpos_d       = qpos_q;
		score_d      = score_q;
		prev_d       = prev_q;
		last_match_d = last_match_q;
		tpos_d       = tpos_q;
		prefix_d     = prefix_q;

		if (item.char_present) begin
			if ((tpos_q < eff_len) && (lc != tq)) begin
				prefix_d = 1'b0;
			end
			if (qpos_q < eff_len) begin
				if (lc == mq) begin
					score_d      = score_q + SCORE_W'(bonus);
					last_match_d = 1'b1;
					qpos_d       = qpos_q + 1'b1;
				end else begin
					last_match_d = 1'b0;
				end
			end
			prev_d = item.target_char;
			if (tpos_q < TPOS_W'(TPOS_SAT)) begin
				tpos_d = tpos_q + 1'b1;
			end
		end

		done  = (qpos_d >= eff_len);
		total = {1'b0, score_d} + (prefix_d ? PTS_PREFIX : '0);
		final_score = '0;
		if ((eff_len != '0) && done) begin
			final_score = total[SCORE_W] ? '1 : total[SCORE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qpos_q       <= '0;
			score_q      <= '0;
			prev_q       <= '0;
			last_match_q <= 1'b0;
			tpos_q       <= '0;
			prefix_q     <= 1'b1;
		end else if (fire) begin
			if (item.last_of_target) begin
				qpos_q       <= '0;
				score_q      <= '0;
				prev_q       <= '0;
				last_match_q <= 1'b0;
				tpos_q       <= '0;
				prefix_q     <= 1'b1;
			end else begin
				qpos_q       <= qpos_d;
				score_q      <= score_d;
				prev_q       <= prev_d;
				last_match_q <= last_match_d;
				tpos_q       <= tpos_d;
				prefix_q     <= prefix_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && item.last_of_target) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item.last_of_target) begin
			out_score_q   <= final_score;
			out_matched_q <= done;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.match_score = out_score_q;
	assign out_ch.matched     = out_matched_q;

	`FSS_ASSERT_NOW(a_qpos_bound, clk, arst_n, 1'b1, qpos_q <= LEN_W'(QUERY_MAX))
	`FSS_ASSERT_NOW(a_tpos_sat, clk, arst_n, 1'b1, tpos_q <= TPOS_W'(TPOS_SAT))
	`FSS_ASSERT_NEXT(a_clear_after_last, clk, arst_n, fire && item.last_of_target,
		qpos_q == '0 && score_q == '0 && tpos_q == '0 && prefix_q)
	`FSS_ASSERT_NOW(a_unmatched_zero, clk, arst_n, out_valid_q && !out_matched_q, out_score_q == '0)

endmodule

[rtl/fuzzy_subsequence_scorer.sv]
// ---------------------------------------------------------------------------
// Fuzzy subsequence scorer
// Greedy case-insensitive subsequence match of a candidate against a query.
// ---------------------------------------------------------------------------
// The candidate streams in one character word per cycle; a new word is
// accepted every cycle while results are being taken. Each word is captured
// in an input register, then matched and scored by the match core, and the
// word marked last loads the result register. The only stall comes from
// the result register: a last character waits while a previous result
// has not been taken. Program the query registers only while no candidate
// is in flight.
module fuzzy_subsequence_scorer #(
	parameter int QUERY_MAX = fss_pkg::QUERY_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	fss_in_if.sink                         in_ch,
	fss_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fss_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fss_pkg::*;

	logic [QUERY_MAX-1:0][CHAR_W-1:0] query_bytes;
	logic [LEN_W-1:0]                 eff_len;
	logic                             item_valid;
	item_t                            item;
	logic                             item_take;

	fss_cfg_regs #(
		.QUERY_MAX(QUERY_MAX)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.query_bytes(query_bytes),
		.eff_len    (eff_len)
	);

	fss_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.item_valid(item_valid),
		.item      (item),
		.item_take (item_take)
	);

	fss_match_core #(
		.QUERY_MAX(QUERY_MAX)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.query_bytes(query_bytes),
		.eff_len    (eff_len),
		.out_ch     (out_ch)
	);

endmodule

[sim/fuzzy_subsequence_scorer_tb.sv]
// ---------------------------------------------------------------------------
// Fuzzy subsequence scorer testbench
// Streams candidate strings against programmed queries and scores each one
// with an independent model of the greedy case-insensitive match. Every
// returned score word is checked against the oldest expected verdict.
// ---------------------------------------------------------------------------
module fuzzy_subsequence_scorer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fss_pkg::*;

	localparam int QUERY_LIMIT   = QUERY_MAX_DEF;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_WORDS  = 1350;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               hit;
	} verdict_t;

	class fss_scoreboard;
		logic [CFG_DATA_W-1:0] query_bytes;
		logic [LEN_W-1:0]      query_len;
		logic [LEN_W-1:0]      cursor;
		logic [SCORE_W-1:0]    score_acc;
		logic [CHAR_W-1:0]     prev_char;
		bit                    prev_hit;
		logic [TPOS_W-1:0]     tpos;
		bit                    prefix_ok;
		verdict_t              awaited[$];
		int                    errors;

		function new();
			query_bytes = '0;
			query_len = '0;
			errors = 0;
			restart();
		endfunction

		function void restart();
			cursor = '0;
			score_acc = '0;
			prev_char = '0;
			prev_hit = 1'b0;
			tpos = '0;
			prefix_ok = 1'b1;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_QUERY_CHARS) begin
				query_bytes = value;
			end else begin
				query_len = value[LEN_W-1:0];
			end
		endfunction

		function bit in_span(logic [CHAR_W-1:0] c, logic [CHAR_W-1:0] lo,
				logic [CHAR_W-1:0] hi);
			return (c >= lo) && (c <= hi);
		endfunction

		function bit alnum(logic [CHAR_W-1:0] c);
			return in_span(c, 8'h61, 8'h7A) || in_span(c, 8'h41, 8'h5A)
				|| in_span(c, 8'h30, 8'h39);
		endfunction

		function logic [CHAR_W-1:0] fold_case(logic [CHAR_W-1:0] c);
			return in_span(c, 8'h41, 8'h5A) ? c + 8'h20 : c;
		endfunction

		function logic [CHAR_W-1:0] query_at(int unsigned idx);
			return query_bytes[(idx % 8) * 8 +: 8];
		endfunction

		// Called once per accepted character word.
		function void note_char(item_t w);
			int unsigned         len;
			int unsigned         pts;
			logic [CHAR_W-1:0]   lc;
			logic [SCORE_W:0]    total;
			verdict_t            v;
			len = (query_len > QUERY_LIMIT) ? QUERY_LIMIT : query_len;
			if (w.char_present) begin
				lc = fold_case(w.target_char);
				if (tpos < len && lc != fold_case(query_at(tpos)))
					prefix_ok = 1'b0;
				if (cursor < len) begin
					if (lc == fold_case(query_at(cursor))) begin
						pts = 5;
						if (tpos == 0) begin
							pts += 25;
						end else if ((in_span(prev_char, 8'h61, 8'h7A)
								&& in_span(w.target_char, 8'h41, 8'h5A))
								|| (!alnum(prev_char) && alnum(w.target_char))) begin
							pts += 10;
						end
						if (prev_hit)
							pts += 8;
						score_acc = score_acc + pts[SCORE_W-1:0];
						prev_hit = 1'b1;
						cursor = cursor + 1'b1;
					end else begin
						prev_hit = 1'b0;
					end
				end
				prev_char = w.target_char;
				if (tpos < TPOS_SAT)
					tpos = tpos + 1'b1;
			end
			if (w.last_of_target) begin
				v.hit = (cursor >= len);
				total = '0;
				if (len > 0 && v.hit) begin
					total = score_acc + (prefix_ok ? 9'd40 : 9'd0);
					if (total > 255)
						total = 255;
				end
				v.score = total[SCORE_W-1:0];
				awaited.insert(awaited.size(), v);
				restart();
			end
		endfunction

		function void check_result(logic [SCORE_W-1:0] score, logic hit);
			verdict_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result: score %0d matched %0b", $time, score, hit);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (want.score !== score || want.hit !== hit) begin
				$display("%0t: result mismatch: expected score %0d matched %0b, %s %0d %s %0b",
					$time, want.score, want.hit, "got score", score, "matched", hit);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fss_in_if  in_ch();
	fss_out_if out_ch();

	fss_scoreboard board;
	int unsigned   cycle_count = 0;
	int unsigned   words_sent = 0;
	bit            steady = 1'b0;
	item_t         cand_q[$];

	fuzzy_subsequence_scorer #(
		.QUERY_MAX(QUERY_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: take the score word, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				board.check_result(out_ch.match_score, out_ch.matched);
			out_ch.ready <= steady || ($urandom_range(99) >= 21);
		end
	end

	function automatic item_t make_word(logic [CHAR_W-1:0] c, logic present, logic last);
		item_t w;
		w.target_char = c;
		w.char_present = present;
		w.last_of_target = last;
		return w;
	endfunction

	function automatic void append_word(item_t w);
		cand_q.insert(cand_q.size(), w);
	endfunction

	function automatic logic [CHAR_W-1:0] pick_char();
		logic [CHAR_W-1:0] c;
		case ($urandom_range(9))
			0, 1, 2, 3: c = 8'h61 + 8'($urandom_range(25));
			4, 5: c = 8'h41 + 8'($urandom_range(25));
			6: c = 8'h30 + 8'($urandom_range(9));
			7: begin
				case ($urandom_range(4))
					0: c = 8'h20;
					1: c = 8'h2D;
					2: c = 8'h5F;
					3: c = 8'h2E;
					default: c = 8'h2F;
				endcase
			end
			8: c = 8'($urandom_range(255));
			default: c = 8'h80 + 8'($urandom_range(127));
		endcase
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] flip_case(logic [CHAR_W-1:0] c);
		if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(1))
			return c ^ 8'h20;
		return c;
	endfunction

	task automatic send_word(input item_t w);
		while (!steady && $urandom_range(99) < 21) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.target_char <= w.target_char;
		in_ch.char_present <= w.char_present;
		in_ch.last_of_target <= w.last_of_target;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		board.note_char(w);
		words_sent++;
	endtask

	task automatic send_candidate();
		foreach (cand_q[i])
			send_word(cand_q[i]);
		cand_q.delete();
	endtask

	// Holds off the sender until every score word is back and the pipe is empty.
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_query(input logic [CFG_DATA_W-1:0] chars,
			input logic [CFG_DATA_W-1:0] len_word);
		cfg_we <= 1'b1;
		cfg_index <= REG_QUERY_CHARS;
		cfg_data <= chars;
		@(posedge clk);
		board.write_reg(REG_QUERY_CHARS, chars);
		cfg_index <= REG_QUERY_LENGTH;
		cfg_data <= len_word;
		@(posedge clk);
		board.write_reg(REG_QUERY_LENGTH, len_word);
		cfg_we <= 1'b0;
	endtask

	// Candidate that carries the query in order, with optional filler between
	// characters, a dropped character, and blank words mixed in.
	task automatic build_matching(input logic [CFG_DATA_W-1:0] chars, input int len,
			input bit exact, input bit drop_one);
		int drop;
		drop = (drop_one && len > 0) ? $urandom_range(len - 1) : -1;
		for (int i = 0; i < len; i++) begin
			if (!exact && $urandom_range(2) == 0) begin
				repeat ($urandom_range(1, 3))
					append_word(make_word(pick_char(), 1'b1, 1'b0));
			end
			if (!exact && $urandom_range(15) == 0)
				append_word(make_word(8'($urandom_range(255)), 1'b0, 1'b0));
			if (i != drop)
				append_word(make_word(flip_case(chars[i * 8 +: 8]), 1'b1, 1'b0));
		end
		repeat ($urandom_range(0, 4))
			append_word(make_word(pick_char(), 1'b1, 1'b0));
		if (cand_q.size() == 0)
			append_word(make_word(pick_char(), 1'b1, 1'b0));
		cand_q[cand_q.size() - 1].last_of_target = 1'b1;
	endtask

	task automatic build_noise();
		repeat ($urandom_range(1, 12))
			append_word(make_word(pick_char(), $urandom_range(7) != 0, 1'b0));
		cand_q[cand_q.size() - 1].last_of_target = 1'b1;
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] chars;
		int unsigned           qlen;
		int unsigned           eff;
		int unsigned           word_goal;
		int unsigned           phase;
		int unsigned           pick;

		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_QUERY_CHARS;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.target_char = '0;
		in_ch.char_present = 1'b0;
		in_ch.last_of_target = 1'b0;
		out_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Query still empty after reset: a character and an empty candidate.
		append_word(make_word(8'h71, 1'b1, 1'b1));
		append_word(make_word(8'h00, 1'b0, 1'b1));
		send_candidate();
		settle();

		// Query "Ab": exact prefix, boundary hits, empty candidate, no match,
		// and characters trailing a full match.
		program_query(64'h6241, 64'd2);
		append_word(make_word(8'h61, 1'b1, 1'b0));
		append_word(make_word(8'h42, 1'b1, 1'b1));
		append_word(make_word(8'h2D, 1'b1, 1'b0));
		append_word(make_word(8'h61, 1'b1, 1'b0));
		append_word(make_word(8'h58, 1'b1, 1'b0));
		append_word(make_word(8'h42, 1'b1, 1'b1));
		append_word(make_word(8'h00, 1'b0, 1'b1));
		append_word(make_word(8'h7A, 1'b1, 1'b0));
		append_word(make_word(8'h7A, 1'b1, 1'b1));
		append_word(make_word(8'h41, 1'b1, 1'b0));
		append_word(make_word(8'h62, 1'b1, 1'b0));
		append_word(make_word(8'h63, 1'b1, 1'b0));
		append_word(make_word(8'hFF, 1'b1, 1'b1));
		send_candidate();
		settle();

		// Shorten the query while a candidate is half done: it counts as matched.
		append_word(make_word(8'h61, 1'b1, 1'b0));
		send_candidate();
		settle();
		program_query(64'h6241, 64'd1);
		append_word(make_word(8'h80, 1'b1, 1'b1));
		send_candidate();
		settle();

		// All-ones query with an oversized length, which clamps to eight.
		program_query('1, '1);
		repeat (7) append_word(make_word(8'hFF, 1'b1, 1'b0));
		append_word(make_word(8'h00, 1'b0, 1'b0));
		append_word(make_word(8'hFF, 1'b1, 1'b1));
		send_candidate();
		settle();

		word_goal = words_sent + RANDOM_WORDS;
		phase = 0;
		while (words_sent < word_goal) begin
			phase++;
			steady = (phase % 5 == 2);
			pick = $urandom_range(19);
			if (pick == 0)
				qlen = 0;
			else if (pick == 1)
				qlen = $urandom_range(9, 15);
			else if (pick < 6)
				qlen = 8;
			else
				qlen = $urandom_range(1, 7);
			for (int i = 0; i < 8; i++)
				chars[i * 8 +: 8] = pick_char();
			program_query(chars, ({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FFF0)
				| 64'(qlen[3:0]));
			eff = (qlen > QUERY_LIMIT) ? QUERY_LIMIT : qlen;
			repeat ($urandom_range(8, 20)) begin
				pick = $urandom_range(99);
				if (pick < 55)
					build_matching(chars, eff, 1'b0, 1'b0);
				else if (pick < 70)
					build_matching(chars, eff, 1'b1, 1'b0);
				else if (pick < 82)
					build_matching(chars, eff, 1'b0, 1'b1);
				else if (pick < 95)
					build_noise();
				else
					append_word(make_word(8'($urandom_range(255)), 1'b0, 1'b1));
				send_candidate();
			end
			// Now and then leave a candidate open across the next query change.
			if ($urandom_range(3) == 0) begin
				build_matching(chars, eff, 1'b0, 1'b0);
				cand_q[cand_q.size() - 1].last_of_target = 1'b0;
				send_candidate();
			end
			settle();
		end

		steady = 1'b0;
		settle();
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
